>>> src/temporal_gaussian_neuron_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the temporal gaussian neuron unit
// Clocked, reset-qualified property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_GAUSSIAN_NEURON_UNIT_MACROS_SVH
`define TEMPORAL_GAUSSIAN_NEURON_UNIT_MACROS_SVH

// same-cycle implication
`define TGN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tgn check failed");

// next-cycle implication
`define TGN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tgn check failed");

`endif

>>> src/tgn_pkg.sv
// ----------------------------------------------------------------------------
// tgn_pkg
// Types, codes and lookup tables shared by the neuron unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tgn_pkg;

    typedef enum logic [1:0] {
        OP_SIGNAL = 2'd0,
        OP_ACTIVATE = 2'd1,
        OP_WAKE = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_ASLEEP = 2'd1,
        ST_FULL = 2'd2,
        ST_BEHIND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_HIDDEN = 2'd0,
        KIND_OUTPUT = 2'd1,
        KIND_INPUT = 2'd2,
        KIND_BIAS = 2'd3
    } t_kind;

    typedef enum logic {
        REG_KIND = 1'b0,
        REG_INTERVAL = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TANH1,
        S_TANH2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic signed [15:0] signal_strength;
        logic [3:0] signal_age;
        logic [31:0] step_number;
    } t_request;

    typedef struct packed {
        logic signed [15:0] node_value;
        logic [1:0] status;
        logic woke;
        logic [4:0] signals_held;
    } t_result;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    localparam logic [15:0] ONE_Q88 = 16'd256;
    localparam logic [3:0] AGE_SAT = 4'd15;
    localparam int SEG_SHIFT = 14;

    localparam logic [15:0] TANH_TAB [0:32] = '{
        16'd0, 16'd8150, 16'd16051, 16'd23485, 16'd30285, 16'd36346, 16'd41625,
        16'd46131, 16'd49912, 16'd53038, 16'd55593, 16'd57660, 16'd59320,
        16'd60647, 16'd61694, 16'd62524, 16'd63179, 16'd63693, 16'd64096,
        16'd64412, 16'd64659, 16'd64852, 16'd65003, 16'd65120, 16'd65212,
        16'd65283, 16'd65339, 16'd65383, 16'd65417, 16'd65443, 16'd65464,
        16'd65480, 16'd65492
    };

    function automatic logic [7:0] age_weight(input logic [3:0] age);
        logic [7:0] w;
        case (age)
            4'd0: w = 8'd204;
            4'd1: w = 8'd28;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/tgn_cell.sv
// ----------------------------------------------------------------------------
// tgn_cell
// One signal slot: holds strength and age, shifts from its neighbor or loads.
// ----------------------------------------------------------------------------
`default_nettype none

module tgn_cell
    import tgn_pkg::*;
(
    input wire logic i_clk,
    input wire t_cell_ctl i_ctl,
    input wire logic signed [15:0] i_load_strength,
    input wire logic [3:0] i_load_age,
    input wire logic signed [15:0] i_next_strength,
    input wire logic [3:0] i_next_age,
    output logic signed [15:0] o_strength,
    output logic [3:0] o_age
);

    logic signed [15:0] r_strength;
    logic [3:0] r_age;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_strength <= i_load_strength;
            r_age <= i_load_age;
        end else if (i_ctl.shift) begin
            r_strength <= i_next_strength;
            r_age <= i_next_age;
        end
    end

    assign o_strength = r_strength;
    assign o_age = r_age;

endmodule

`default_nettype wire

>>> src/tgn_tanh.sv
// ----------------------------------------------------------------------------
// tgn_tanh
// Two-stage tanh(sum/2): magnitude and segment, then table interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module tgn_tanh
    import tgn_pkg::*;
#(
    parameter int SW = 29
) (
    input wire logic i_clk,
    input wire logic signed [SW-1:0] i_sum,
    output logic signed [15:0] o_value
);

    logic [SW-1:0] mag;
    logic r_neg;
    logic r_sat;
    logic [4:0] r_seg;
    logic [13:0] r_frac;
    logic signed [15:0] r_value;
    logic [15:0] lo;
    logic [15:0] diff;
    logic [31:0] interp;
    logic [9:0] res;

    assign mag = i_sum[SW-1] ? SW'(-i_sum) : SW'(i_sum);

    always_ff @(posedge i_clk) begin
        r_neg <= i_sum[SW-1];
        r_sat <= |mag[SW-1:SEG_SHIFT+5];
        r_seg <= mag[SEG_SHIFT+4:SEG_SHIFT];
        r_frac <= mag[SEG_SHIFT-1:0];
    end

    always_comb begin
        lo = TANH_TAB[r_seg];
        diff = TANH_TAB[6'(r_seg) + 6'd1] - lo;
        interp = {2'b0, lo, 14'b0} + 32'(diff) * 32'(r_frac) + 32'h0020_0000;
        res = r_sat ? 10'(ONE_Q88) : interp[31:22];
    end

    always_ff @(posedge i_clk) begin
        r_value <= r_neg ? -$signed({6'b0, res}) : $signed({6'b0, res});
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

>>> src/temporal_gaussian_neuron_unit.sv
// ----------------------------------------------------------------------------
// temporal_gaussian_neuron_unit
// Neuron node buffering timed signals in a chain of slot cells.
// ----------------------------------------------------------------------------
// Requests enter on i_request when start is high and busy is low. Each request
// gives exactly one result on o_result, shown for one cycle with o_strobe; the
// receiver cannot stall, so results are never held back.
// Signal, wake, empty and skipped activate requests answer in the cycle after
// acceptance and leave busy low. A performed activate keeps busy high. On a
// non-input node it walks the held signals through the cell chain, one slot
// per cycle; hidden and output nodes then pass the sum through S_TANH1 and
// S_TANH2, S_OUT loads the result, and the result shows in the cycle after
// that. Input nodes go from acceptance straight to S_OUT. The result of a
// performed activate shows in the same cycle in which the next request can enter.
// Configuration is written over i_cfg_valid / i_cfg_index / i_cfg_data;
// o_cfg_ready is high only while the unit is idle.
// Reset clears held count, sleep count, step count and the configuration
// (kind hidden, interval 1). Slot contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_gaussian_neuron_unit
    import tgn_pkg::*;
#(
    parameter int SIGNAL_SLOTS = 16,
    parameter int MAX_AGE = 8
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    output logic busy,
    input wire t_request i_request,
    output logic o_strobe,
    output t_result o_result,
    input wire logic i_cfg_valid,
    output logic o_cfg_ready,
    input wire logic i_cfg_index,
    input wire logic [7:0] i_cfg_data
);

    localparam int CW = $clog2(SIGNAL_SLOTS + 1);
    localparam int IW = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;
    localparam int SW = 25 + CW;

    t_state r_state, n_state;
    logic [CW-1:0] r_held, r_k, r_kept;
    logic [7:0] r_sleep;
    logic [31:0] r_done;
    logic signed [SW-1:0] r_acc;
    logic signed [15:0] r_val;
    t_kind r_kind;
    logic [7:0] r_intv;
    logic r_strobe;
    t_result r_result;

    logic signed [15:0] cs [SIGNAL_SLOTS];
    logic [3:0] ca [SIGNAL_SLOTS];
    logic shift_en, load_en;
    logic [IW-1:0] load_idx;
    logic signed [15:0] load_s;
    logic [3:0] load_a;

    logic accept, perform, neural, walk_last;
    logic [3:0] age_new;
    logic keep;
    logic [CW:0] push_pos;
    logic signed [24:0] prod;
    logic signed [15:0] tanh_val;

    assign accept = start && !busy;
    assign neural = (r_kind == KIND_HIDDEN) || (r_kind == KIND_OUTPUT);
    assign perform = accept && (i_request.operation == OP_ACTIVATE)
        && !(i_request.step_number < r_done) && (r_sleep == 8'd0);
    assign walk_last = (r_k == r_held - CW'(1));

    assign age_new = (neural && (ca[0] != AGE_SAT)) ? ca[0] + 4'd1 : ca[0];
    assign keep = (age_new <= 4'(MAX_AGE));
    assign push_pos = (CW+1)'(r_held) + (CW+1)'(r_kept) - (CW+1)'(r_k) - (CW+1)'(1);
    assign prod = cs[0] * $signed({1'b0, age_weight(ca[0])});

    generate
        for (genvar i = 0; i < SIGNAL_SLOTS; i++) begin : g_cell
            t_cell_ctl ctl;
            assign ctl = {shift_en, load_en && (load_idx == IW'(i))};
            tgn_cell u_cell (
                .i_clk(i_clk),
                .i_ctl(ctl),
                .i_load_strength(load_s),
                .i_load_age(load_a),
                .i_next_strength(cs[(i < SIGNAL_SLOTS-1) ? i+1 : i]),
                .i_next_age(ca[(i < SIGNAL_SLOTS-1) ? i+1 : i]),
                .o_strength(cs[i]),
                .o_age(ca[i])
            );
        end
    endgenerate

    tgn_tanh #(.SW(SW)) u_tanh (
        .i_clk(i_clk),
        .i_sum(r_acc),
        .o_value(tanh_val)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (perform) begin
                    if (r_kind == KIND_INPUT) begin
                        n_state = S_OUT;
                    end else if (r_held != '0) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = neural ? S_TANH1 : S_OUT;
                    end
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = neural ? S_TANH1 : S_OUT;
                end
            end
            S_TANH1: n_state = S_TANH2;
            S_TANH2: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy = 1'b1;
        shift_en = 1'b0;
        load_en = 1'b0;
        load_idx = '0;
        load_s = i_request.signal_strength;
        load_a = i_request.signal_age;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (accept && (i_request.operation == OP_SIGNAL)) begin
                    if (r_kind == KIND_INPUT) begin
                        load_en = 1'b1;
                    end else if (r_kind != KIND_BIAS && r_held < CW'(SIGNAL_SLOTS)) begin
                        load_en = 1'b1;
                        load_idx = IW'(r_held);
                    end
                end
            end
            S_WALK: begin
                shift_en = 1'b1;
                load_en = keep;
                load_idx = IW'(push_pos);
                load_s = cs[0];
                load_a = age_new;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held <= '0;
            r_sleep <= '0;
            r_done <= '0;
            r_kind <= KIND_HIDDEN;
            r_intv <= 8'd1;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_valid && r_state == S_IDLE) begin
                unique case (t_reg'(i_cfg_index))
                    REG_KIND: r_kind <= t_kind'(i_cfg_data[1:0]);
                    REG_INTERVAL: r_intv <= i_cfg_data;
                    default: r_intv <= r_intv;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_result.node_value <= '0;
                        r_result.status <= ST_OK;
                        r_result.woke <= 1'b0;
                        r_result.signals_held <= 5'(r_held);
                        r_strobe <= !perform;
                        case (i_request.operation)
                            OP_SIGNAL: begin
                                if (r_kind == KIND_INPUT) begin
                                    if (r_held == '0) begin
                                        r_held <= CW'(1);
                                        r_result.signals_held <= 5'd1;
                                    end
                                end else if (r_kind != KIND_BIAS) begin
                                    if (r_held < CW'(SIGNAL_SLOTS)) begin
                                        r_held <= r_held + CW'(1);
                                        r_result.signals_held <= 5'(r_held + CW'(1));
                                    end else begin
                                        r_result.status <= ST_FULL;
                                    end
                                end
                            end
                            OP_ACTIVATE: begin
                                if (i_request.step_number < r_done) begin
                                    r_result.status <= ST_BEHIND;
                                end else if (r_sleep != 8'd0) begin
                                    r_result.status <= ST_ASLEEP;
                                end else begin
                                    r_sleep <= r_intv;
                                    r_done <= r_done + 32'd1;
                                    r_k <= '0;
                                    r_kept <= '0;
                                    r_acc <= '0;
                                    if (r_kind == KIND_INPUT) begin
                                        r_val <= (r_held != '0) ? cs[0] : 16'sd0;
                                        r_held <= '0;
                                    end else begin
                                        r_val <= $signed(ONE_Q88);
                                    end
                                end
                            end
                            OP_WAKE: begin
                                if (r_sleep <= 8'd1) begin
                                    r_sleep <= '0;
                                    r_result.woke <= 1'b1;
                                end else begin
                                    r_sleep <= r_sleep - 8'd1;
                                end
                            end
                            default: r_result.status <= ST_OK;
                        endcase
                    end
                end
                S_WALK: begin
                    r_k <= r_k + CW'(1);
                    r_kept <= r_kept + CW'(keep);
                    r_acc <= r_acc + SW'(prod);
                end
                S_OUT: begin
                    r_held <= (r_kind == KIND_INPUT) ? '0 : r_kept;
                    r_result.node_value <= neural ? tanh_val : r_val;
                    r_result.status <= ST_OK;
                    r_result.woke <= 1'b0;
                    r_result.signals_held <= (r_kind == KIND_INPUT) ? 5'd0 : 5'(r_kept);
                    r_strobe <= 1'b1;
                end
                default: r_k <= r_k;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign o_cfg_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> src/tgn_checker.sv
// ----------------------------------------------------------------------------
// tgn_checker
// Port-level checks on the neuron unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_gaussian_neuron_unit_macros.svh"

module tgn_checker
    import tgn_pkg::*;
#(
    parameter int SIGNAL_SLOTS = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe,
    input wire t_result o_result
);

    `TGN_ASSERT_NEXT(a_req_answered, start && !busy, busy || o_strobe)
    `TGN_ASSERT_NOW(a_error_zero, o_strobe && o_result.status != ST_OK, o_result.node_value == 16'sd0)
    `TGN_ASSERT_NOW(a_woke_clean, o_strobe && o_result.woke, o_result.status == ST_OK && o_result.node_value == 16'sd0)
    `TGN_ASSERT_NOW(a_held_range, o_strobe && SIGNAL_SLOTS < 32, 32'(o_result.signals_held) <= SIGNAL_SLOTS)

endmodule

bind temporal_gaussian_neuron_unit tgn_checker #(.SIGNAL_SLOTS(SIGNAL_SLOTS)) u_tgn_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

`default_nettype wire

>>> test/temporal_gaussian_neuron_unit_test.sv
// ----------------------------------------------------------------------------
// temporal_gaussian_neuron_unit_test
// Self-checking bench: signal, activate, wake and empty requests run under
// several node kinds and sleep intervals. Each accepted request is predicted
// and queued; every strobed result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module temporal_gaussian_neuron_unit_test;
    import tgn_pkg::*;

    class neuron_forecast;
        logic signed [15:0] str_slot [16];
        logic [3:0] age_slot [16];
        int held;
        int sleep_left;
        logic [31:0] steps_done;
        t_kind kind;
        logic [7:0] interval;
        t_result awaited [$];
        int mismatches;

        function new();
            held = 0;
            sleep_left = 0;
            steps_done = 0;
            kind = KIND_HIDDEN;
            interval = 8'd1;
            mismatches = 0;
        endfunction

        function void set_reg(t_reg idx, logic [7:0] data);
            if (idx == REG_KIND) kind = t_kind'(data[1:0]);
            else interval = data;
        endfunction

        function logic signed [15:0] squash(longint sum);
            longint unsigned mag, seg, frac, v, lo, diff;
            logic [15:0] res;
            mag = (sum < 0) ? -sum : sum;
            seg = mag >> SEG_SHIFT;
            if (seg >= 32) begin
                res = ONE_Q88;
            end else begin
                lo = TANH_TAB[seg];
                diff = TANH_TAB[seg + 1];
                diff = diff - lo;
                frac = mag & 64'h3FFF;
                v = (lo << SEG_SHIFT) + diff * frac;
                res = 16'((v + (64'd1 << 21)) >> 22);
            end
            return (sum < 0) ? -res : res;
        endfunction

        function void note_request(t_request r);
            t_result e;
            longint sum;
            int j, w;
            e = '0;
            case (t_op'(r.operation))
                OP_SIGNAL: begin
                    if (kind == KIND_INPUT) begin
                        str_slot[0] = r.signal_strength;
                        age_slot[0] = r.signal_age;
                        if (held == 0) held = 1;
                    end else if (kind != KIND_BIAS) begin
                        if (held < 16) begin
                            str_slot[held] = r.signal_strength;
                            age_slot[held] = r.signal_age;
                            held++;
                        end else begin
                            e.status = ST_FULL;
                        end
                    end
                end
                OP_ACTIVATE: begin
                    if (r.step_number < steps_done) begin
                        e.status = ST_BEHIND;
                    end else if (sleep_left > 0) begin
                        e.status = ST_ASLEEP;
                    end else begin
                        sleep_left = interval;
                        if (kind == KIND_INPUT) begin
                            e.node_value = (held > 0) ? str_slot[0] : 16'sd0;
                            held = 0;
                        end else if (kind == KIND_BIAS) begin
                            e.node_value = ONE_Q88;
                        end else begin
                            sum = 0;
                            for (int i = 0; i < held; i++) begin
                                w = (age_slot[i] == 0) ? 204 : (age_slot[i] == 1) ? 28 : 0;
                                sum += longint'(str_slot[i]) * w;
                            end
                            e.node_value = squash(sum);
                            for (int i = 0; i < held; i++)
                                if (age_slot[i] < AGE_SAT) age_slot[i]++;
                        end
                        j = 0;
                        for (int i = 0; i < held; i++) begin
                            if (age_slot[i] <= 8) begin
                                str_slot[j] = str_slot[i];
                                age_slot[j] = age_slot[i];
                                j++;
                            end
                        end
                        held = j;
                        steps_done++;
                    end
                end
                OP_WAKE: begin
                    if (sleep_left <= 1) begin
                        sleep_left = 0;
                        e.woke = 1'b1;
                    end else begin
                        sleep_left--;
                    end
                end
                default: ;
            endcase
            e.signals_held = 5'(held);
            awaited.insert(awaited.size(), e);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (awaited.size() == 0) begin
                $error("result without pending request: %p", got);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (got.node_value !== e.node_value) begin
                $error("node_value expected %0d actual %0d", e.node_value, got.node_value);
                mismatches++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status);
                mismatches++;
            end
            if (got.woke !== e.woke) begin
                $error("woke expected %0d actual %0d", e.woke, got.woke);
                mismatches++;
            end
            if (got.signals_held !== e.signals_held) begin
                $error("signals_held expected %0d actual %0d", e.signals_held,
                       got.signals_held);
                mismatches++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_request i_request;
    logic o_strobe;
    t_result o_result;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_index;
    logic [7:0] i_cfg_data;

    neuron_forecast sb = new();
    int stall_cycles;
    bit idling_on;

    temporal_gaussian_neuron_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_request(i_request),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_request(i_request);
            if (o_strobe) sb.check_result(o_result);
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(t_reg'(i_cfg_index), i_cfg_data);
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send(t_request r);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_request <= r;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.awaited.size() > 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic configure(t_kind kind, logic [7:0] interval);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_KIND;
        i_cfg_data <= 8'(kind);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_INTERVAL;
        i_cfg_data <= interval;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_request make_req(t_op op, logic [15:0] s, logic [3:0] a,
                                          logic [31:0] step);
        t_request r;
        r.operation = op;
        r.signal_strength = s;
        r.signal_age = a;
        r.step_number = step;
        return r;
    endfunction

    function automatic t_request random_req();
        int pick;
        logic [15:0] s;
        logic [3:0] a;
        logic [31:0] step;
        t_op op;
        pick = $urandom_range(0, 99);
        op = (pick < 50) ? OP_SIGNAL : (pick < 75) ? OP_ACTIVATE :
             (pick < 95) ? OP_WAKE : OP_NONE;
        pick = $urandom_range(0, 9);
        if (pick < 4) s = 16'($urandom);
        else if (pick < 8) s = 16'($urandom_range(0, 1200) - 600);
        else s = (pick == 8) ? 16'h7FFF : 16'h8000;
        a = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 1)) : 4'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 8) step = sb.steps_done + $urandom_range(0, 3);
        else if (pick == 8) step = sb.steps_done - 1;
        else step = $urandom;
        return make_req(op, s, a, step);
    endfunction

    initial begin
        t_kind kinds [9];
        logic [7:0] gaps [9];
        kinds = '{KIND_HIDDEN, KIND_OUTPUT, KIND_INPUT, KIND_BIAS, KIND_HIDDEN,
                  KIND_OUTPUT, KIND_INPUT, KIND_HIDDEN, KIND_BIAS};
        gaps = '{8'd1, 8'd2, 8'd1, 8'd3, 8'd0, 8'd255, 8'd0, 8'd3, 8'd1};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_request = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_KIND;
        i_cfg_data = '0;
        stall_cycles = 0;
        idling_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(KIND_HIDDEN, 8'd1);
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'd0));
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'd5));
        send(make_req(OP_WAKE, 16'h0000, 4'd0, 32'd0));
        send(make_req(OP_WAKE, 16'h0000, 4'd0, 32'd0));
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'd0));
        send(make_req(OP_SIGNAL, 16'h7FFF, 4'd0, 32'hFFFF_FFFF));
        send(make_req(OP_SIGNAL, 16'h8000, 4'd1, 32'd0));
        send(make_req(OP_SIGNAL, 16'h0100, 4'd15, 32'd0));
        send(make_req(OP_SIGNAL, 16'h0040, 4'd8, 32'd0));
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'hFFFF_FFFF));
        send(make_req(OP_NONE, 16'hFFFF, 4'd15, 32'hFFFF_FFFF));
        send(make_req(OP_WAKE, 16'h0000, 4'd0, 32'd0));
        send(make_req(OP_SIGNAL, 16'h0020, 4'd0, 32'd0));
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'd3));
        drain();
        configure(KIND_INPUT, 8'd0);
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'd3));
        send(make_req(OP_SIGNAL, 16'h8000, 4'd3, 32'd0));
        send(make_req(OP_SIGNAL, 16'h1234, 4'd9, 32'd0));
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'd4));
        drain();
        configure(KIND_BIAS, 8'd0);
        send(make_req(OP_SIGNAL, 16'h7FFF, 4'd0, 32'd0));
        send(make_req(OP_ACTIVATE, 16'h0000, 4'd0, 32'd9));
        drain();

        for (int p = 0; p < 9; p++) begin
            configure(kinds[p], gaps[p]);
            if (p == 8) idling_on = 1'b0;
            for (int n = 0; n < 150; n++) begin
                if (p == 2 && n == 75) drain();
                send(random_req());
            end
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/tgn_pkg.sv
src/tgn_cell.sv
src/tgn_tanh.sv
src/temporal_gaussian_neuron_unit.sv
src/tgn_checker.sv
test/temporal_gaussian_neuron_unit_test.sv
